// File: src/mep_pkg.sv
// Package for the escape-time pixel engine: widths, codes, command/status types
// and the saturating fixed-point helpers.
// Depends on nothing; every other file of the block imports it.
package mep_pkg;

	localparam int FRAC_BITS = 28;
	localparam int VAL_W     = FRAC_BITS + 4;
	localparam int MAX_DIM   = 4096;
	localparam int DIM_W     = 13;
	localparam int ITER_W    = 12;
	localparam int PIX_W     = 12;
	localparam int SCALE_W   = 31;
	localparam int CFG_W     = 32;
	localparam int IDX_W     = 3;
	localparam int COLOR_W   = 24;
	localparam int DIV_W     = 45;
	localparam int DCNT_W    = 6;
	localparam int WIDE_W    = 48;

	localparam logic [IDX_W-1:0] REG_SCALE     = 3'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_RE = 3'd1;
	localparam logic [IDX_W-1:0] REG_CENTER_IM = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_ITER  = 3'd3;
	localparam logic [IDX_W-1:0] REG_WIDTH     = 3'd4;
	localparam logic [IDX_W-1:0] REG_HEIGHT    = 3'd5;

	localparam logic signed [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_FOUR = VAL_W'(4) <<< FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV_GO, S_DIV_WAIT, S_CHECK, S_UPDATE,
		S_MUL_XX, S_TAKE_XX, S_TAKE_YY, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		DSEL_RE, DSEL_IM, DSEL_BLUE, DSEL_GREEN, DSEL_RED
	} div_sel_t;

	typedef enum logic [1:0] {
		MSEL_XY, MSEL_XX, MSEL_YY
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		logic     div_take;
		div_sel_t sel;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     update;
		logic     take_sqx;
		logic     take_sqy;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic cont;
		logic below_m;
	} status_t;

	typedef struct packed {
		logic [SCALE_W-1:0]      scale;
		logic signed [CFG_W-1:0] center_re;
		logic signed [CFG_W-1:0] center_im;
		logic [ITER_W-1:0]       max_iter;
		logic [DIM_W-1:0]        width;
		logic [DIM_W-1:0]        height;
	} cfg_t;

	// Clamp a wide signed sum into the value range.
	function automatic logic signed [VAL_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(VAL_MAX);
		lo = WIDE_W'(VAL_MIN);
		if (v > hi) return VAL_MAX;
		if (v < lo) return VAL_MIN;
		return v[VAL_W-1:0];
	endfunction

	// Saturating add of two values.
	function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b);
		logic signed [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VAL_MIN : VAL_MAX;
		return s[VAL_W-1:0];
	endfunction

	// Clamp an image dimension to [1, MAX_DIM].
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		if (d == '0) return DIM_W'(1);
		if (d > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
		return d;
	endfunction

endpackage

// File: src/mandelbrot_escape_pixel_top.sv
// The palette divisions run only when the point escapes; each division uses a
// one-bit-per-cycle divider.
// Throughput: one item at a time; busy stays high until the done strobe.
// The orbit step runs through S_CHECK, S_UPDATE, S_MUL_XX, S_TAKE_XX and S_TAKE_YY, using the one shared multiplier.
// Reset (arst_n low) clears the controller and loads the register defaults.
// Results are valid with done, which is high for one cycle; the receiver cannot stall.
module mandelbrot_escape_pixel_top
	import mep_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic [PIX_W-1:0]   row,
	input  logic [PIX_W-1:0]   col,
	output logic [ITER_W-1:0]  iter_count,
	output logic [COLOR_W-1:0] color,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t stat;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale     <= SCALE_W'(268435456);
			cfg_q.center_re <= '0;
			cfg_q.center_im <= '0;
			cfg_q.max_iter  <= ITER_W'(100);
			cfg_q.width     <= DIM_W'(640);
			cfg_q.height    <= DIM_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE:     cfg_q.scale     <= cfg_data[SCALE_W-1:0];
				REG_CENTER_RE: cfg_q.center_re <= cfg_data;
				REG_CENTER_IM: cfg_q.center_im <= cfg_data;
				REG_MAX_ITER:  cfg_q.max_iter  <= cfg_data[ITER_W-1:0];
				REG_WIDTH:     cfg_q.width     <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:    cfg_q.height    <= cfg_data[DIM_W-1:0];
				default:       cfg_q.scale     <= cfg_q.scale;
			endcase
		end
	end

	mep_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mep_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.row        (row),
		.col        (col),
		.cmd        (cmd),
		.stat       (stat),
		.iter_count (iter_count),
		.color      (color)
	);

endmodule

// File: src/mep_div.sv
// Restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on mep_pkg.
module mep_div
	import mep_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [DIM_W-1:0]  divisor,
	output logic [DIV_W-1:0]  quot,
	output logic              rem_nz,
	output logic              done
);

	logic [DIV_W-1:0]  dvd_q;
	logic [DIM_W-1:0]  rem_q;
	logic [DIM_W-1:0]  dsr_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              done_q;
	logic [DIM_W:0]    trial;
	logic              fits;

	// Shift the next dividend bit into the remainder and test it.
	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	// Control: count the steps, pulse done after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DCNT_W'(DIV_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - DCNT_W'(1);
			done_q <= (cnt_q == DCNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: quotient bits shift in where dividend bits leave.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DIV_W-2:0], fits};
			rem_q <= fits ? DIM_W'(trial - {1'b0, dsr_q}) : trial[DIM_W-1:0];
		end
	end

	assign quot   = dvd_q;
	assign rem_nz = (rem_q != '0);
	assign done   = done_q;

endmodule

// File: src/mep_datapath.sv
// Datapath: coordinate mapping, shared multiplier, orbit registers, palette.
// Depends on mep_pkg and mep_div.
module mep_datapath
	import mep_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic [PIX_W-1:0]   row,
	input  logic [PIX_W-1:0]   col,
	input  cmd_t               cmd,
	output status_t            stat,
	output logic [ITER_W-1:0]  iter_count,
	output logic [COLOR_W-1:0] color
);

	logic [DIM_W-1:0] w_clamp;
	logic [DIM_W-1:0] h_clamp;

	logic [DIV_W-1:0]  num_re_q;
	logic [DIV_W-1:0]  num_im_q;
	logic              im_neg_q;
	logic signed [VAL_W-1:0] cre_q, cim_q, x_q, y_q, sqx_q, sqy_q;
	logic [ITER_W-1:0]  it_q;
	logic [COLOR_W-1:0] color_q;
	logic [2*VAL_W-1:0] prod_q;
	logic               pneg_q;

	logic signed [14:0] dim_d;
	logic [13:0]        dim_mag;
	logic [45:0]        im_prod;
	logic [44:0]        re_prod;

	logic signed [VAL_W-1:0] mul_a, mul_b, mul_res;
	logic [VAL_W-1:0]        mag_a, mag_b;
	logic [VAL_W+3:0]        prod_sh;

	logic signed [15:0] pal_n;
	logic [14:0]        pal_mag;
	logic               pal_neg;
	logic [DIV_W-1:0]   div_dvd;
	logic [DIM_W-1:0]   div_dsr;
	logic [DIV_W-1:0]   div_quot;
	logic               div_rem_nz;
	logic               div_done;
	logic [DIV_W-1:0]   neg_quot;
	logic [7:0]         pal_byte;

	logic signed [WIDE_W-1:0] re_sum, im_q_s, im_sum;

	assign w_clamp = clamp_dim(cfg.width);
	assign h_clamp = clamp_dim(cfg.height);

	// Pixel offsets scaled by the zoom, ahead of the divisions.
	assign re_prod = 45'(col) * 45'({cfg.scale, 2'b00});
	assign dim_d   = $signed({2'b00, row, 1'b0}) - $signed({2'b00, h_clamp});
	assign dim_mag = dim_d[14] ? 14'(-dim_d) : dim_d[13:0];
	assign im_prod = 46'(dim_mag) * 46'({cfg.scale, 1'b0});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_re_q <= re_prod;
			num_im_q <= im_prod[DIV_W-1:0];
			im_neg_q <= dim_d[14];
		end
	end

	// Palette numerator for the selected ramp.
	always_comb begin
		case (cmd.sel)
			DSEL_BLUE:  pal_n = $signed({4'b0, cfg.max_iter}) - $signed({3'b0, it_q, 1'b0});
			DSEL_GREEN: pal_n = $signed({4'b0, cfg.max_iter}) - $signed({2'b0, it_q, 2'b00});
			default:    pal_n = $signed({5'b0, it_q[ITER_W-1:1]});
		endcase
	end
	assign pal_neg = pal_n[15];
	assign pal_mag = pal_neg ? 15'(-pal_n) : pal_n[14:0];

	// Pick the dividend and divisor for the division in hand.
	always_comb begin
		case (cmd.sel)
			DSEL_RE: begin
				div_dvd = num_re_q;
				div_dsr = w_clamp;
			end
			DSEL_IM: begin
				div_dvd = num_im_q;
				div_dsr = h_clamp;
			end
			default: begin
				div_dvd = {22'b0, pal_mag, 8'b0};
				div_dsr = {1'b0, cfg.max_iter};
			end
		endcase
	end

	mep_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.quot     (div_quot),
		.rem_nz   (div_rem_nz),
		.done     (div_done)
	);

	// Finish the coordinates: offset, floor correction, saturate.
	assign neg_quot = -div_quot;
	assign re_sum   = WIDE_W'(cfg.center_re) - $signed({16'b0, cfg.scale, 1'b0})
			+ $signed({3'b0, div_quot});
	assign im_q_s   = im_neg_q ? (-$signed({3'b0, div_quot}) - $signed(WIDE_W'(div_rem_nz)))
			: $signed({3'b0, div_quot});
	assign im_sum   = WIDE_W'(cfg.center_im) + im_q_s;
	assign pal_byte = pal_neg ? neg_quot[7:0] : div_quot[7:0];

	// Shared multiplier: sign-magnitude product, registered.
	always_comb begin
		case (cmd.mul_sel)
			MSEL_XY: begin
				mul_a = x_q;
				mul_b = y_q;
			end
			MSEL_XX: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			default: begin
				mul_a = y_q;
				mul_b = y_q;
			end
		endcase
		mag_a = mul_a[VAL_W-1] ? VAL_W'(-mul_a) : VAL_W'(mul_a);
		mag_b = mul_b[VAL_W-1] ? VAL_W'(-mul_b) : VAL_W'(mul_b);
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mag_a * mag_b;
			pneg_q <= mul_a[VAL_W-1] ^ mul_b[VAL_W-1];
		end
	end

	// Drop fraction bits toward zero, saturate, restore the sign.
	assign prod_sh = prod_q[2*VAL_W-1:FRAC_BITS];
	always_comb begin
		if (prod_sh[VAL_W+3:VAL_W-1] != '0) begin
			mul_res = pneg_q ? VAL_MIN : VAL_MAX;
		end else begin
			mul_res = pneg_q ? -$signed(prod_sh[VAL_W-1:0]) : $signed(prod_sh[VAL_W-1:0]);
		end
	end

	// Orbit, coordinate and color registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			color_q <= '0;
		end
		if (cmd.div_take) begin
			case (cmd.sel)
				DSEL_RE: cre_q <= sat_wide(re_sum);
				DSEL_IM: begin
					cim_q <= sat_wide(im_sum);
					x_q   <= '0;
					y_q   <= '0;
					sqx_q <= '0;
					sqy_q <= '0;
					it_q  <= '0;
				end
				DSEL_BLUE:  color_q[7:0]   <= pal_byte;
				DSEL_GREEN: color_q[15:8]  <= pal_byte;
				default:    color_q[23:16] <= pal_byte;
			endcase
		end
		if (cmd.update) begin
			x_q  <= sat_add(sat_add(sqx_q, -sqy_q), cre_q);
			y_q  <= sat_add(sat_add(mul_res, mul_res), cim_q);
			it_q <= it_q + ITER_W'(1);
		end
		if (cmd.take_sqx) begin
			sqx_q <= mul_res;
		end
		if (cmd.take_sqy) begin
			sqy_q <= mul_res;
		end
	end

	assign stat.div_done = div_done;
	assign stat.below_m  = it_q < cfg.max_iter;
	assign stat.cont     = (sat_add(sqx_q, sqy_q) <= VAL_FOUR) && stat.below_m;
	assign iter_count    = it_q;
	assign color         = color_q;

endmodule

// File: src/mep_ctrl.sv
// Controller: sequences divisions, orbit steps and the palette for one item.
// Depends on mep_pkg.
module mep_ctrl
	import mep_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t stat,
	output cmd_t    cmd,
	output logic    busy,
	output logic    done
);

	state_t   state_q, state_d;
	div_sel_t sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= DSEL_RE;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DIV_GO;
					sel_d   = DSEL_RE;
				end
			end
			S_DIV_GO: state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (stat.div_done) begin
					unique case (sel_q)
						DSEL_RE: begin
							sel_d   = DSEL_IM;
							state_d = S_DIV_GO;
						end
						DSEL_IM: state_d = S_CHECK;
						DSEL_BLUE: begin
							sel_d   = DSEL_GREEN;
							state_d = S_DIV_GO;
						end
						DSEL_GREEN: begin
							sel_d   = DSEL_RED;
							state_d = S_DIV_GO;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_CHECK: begin
				if (stat.cont) begin
					state_d = S_UPDATE;
				end else if (stat.below_m) begin
					sel_d   = DSEL_BLUE;
					state_d = S_DIV_GO;
				end else begin
					state_d = S_DONE;
				end
			end
			S_UPDATE:  state_d = S_MUL_XX;
			S_MUL_XX:  state_d = S_TAKE_XX;
			S_TAKE_XX: state_d = S_TAKE_YY;
			S_TAKE_YY: state_d = S_CHECK;
			S_DONE:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd           = '0;
		cmd.sel       = sel_q;
		cmd.mul_sel   = MSEL_XY;
		unique case (state_q)
			S_IDLE:     cmd.load = start;
			S_DIV_GO:   cmd.div_start = 1'b1;
			S_DIV_WAIT: cmd.div_take = stat.div_done;
			S_CHECK:    cmd.mul_en = 1'b1;
			S_UPDATE:   cmd.update = 1'b1;
			S_MUL_XX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_XX;
			end
			S_TAKE_XX: begin
				cmd.take_sqx = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MSEL_YY;
			end
			S_TAKE_YY:  cmd.take_sqy = 1'b1;
			default:    cmd.load = 1'b0;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not make the block busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block stayed busy after delivering an item");
	a_take_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_take |-> stat.div_done && !cmd.div_start)
		else $error("division result taken before the divider finished");
	a_step_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> cmd.mul_en ##1 cmd.take_sqx ##1 cmd.take_sqy)
		else $error("orbit step sequence broken");
`endif

endmodule
